FILE: rtl/heun_damped_oscillator_step_assert.svh
// Assertion macros used by the checker of the Heun oscillator block.
// Each macro expects clk and rst_n in scope.
`ifndef HEUN_DAMPED_OSCILLATOR_STEP_ASSERT_SVH
`define HEUN_DAMPED_OSCILLATOR_STEP_ASSERT_SVH

// Same-cycle implication.
`define HDOS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication; cons may open with a further cycle delay.
`define HDOS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

FILE: rtl/hdos_pkg.sv
package hdos_pkg;

    localparam int WORD_W    = 32;   // Q16.16 state and results
    localparam int CFG_W     = 31;   // unsigned Q15.16 registers
    localparam int CFG_IDX_W = 2;
    localparam int OPND_W    = 33;   // multiplier operand width
    localparam int PROD_W    = 2 * OPND_W;
    localparam int SUM_W     = OPND_W + 2;
    localparam int Q_FRAC    = 16;
    localparam int STEP_W    = 5;

    localparam logic [STEP_W-1:0] LAST_STEP = 5'd29;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [CFG_W-1:0] OMEGA_SQ_RST   = 31'd65536;
    localparam logic [CFG_W-1:0] DRAG_COEFF_RST = 31'd65536;
    localparam logic [CFG_W-1:0] TIME_STEP_RST  = 31'd412;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OMEGA_SQ   = 2'd0,
        REG_DRAG_COEFF = 2'd1,
        REG_TIME_STEP  = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ALU_MUL   = 2'd0,
        ALU_RND16 = 2'd1,   // round and rescale a product by 2^16
        ALU_RND17 = 2'd2,   // same, with the halving folded in
        ALU_ADD   = 2'd3
    } alu_op_t;

    typedef enum logic [3:0] {
        SRC_ZERO  = 4'd0,
        SRC_POS   = 4'd1,
        SRC_VEL   = 4'd2,
        SRC_OMEGA = 4'd3,
        SRC_DRAG  = 4'd4,
        SRC_DT    = 4'd5,
        SRC_T0    = 4'd6,
        SRC_T1    = 4'd7,
        SRC_A0    = 4'd8,
        SRC_XP    = 4'd9,
        SRC_VP    = 4'd10,
        SRC_SUM   = 4'd11
    } src_t;

    typedef enum logic [3:0] {
        DST_NONE = 4'd0,
        DST_T0   = 4'd1,
        DST_T1   = 4'd2,
        DST_A0   = 4'd3,
        DST_XP   = 4'd4,
        DST_VP   = 4'd5,
        DST_SUM  = 4'd6,
        DST_POS  = 4'd7,
        DST_VEL  = 4'd8
    } dst_t;

    typedef struct packed {
        alu_op_t alu;
        src_t    src_a;
        src_t    src_b;
        logic    neg_a;
        logic    neg_b;
        logic    abs_a;   // negate operand a when it is negative
        logic    sat;     // clamp the sum to the word range
        dst_t    dst;
    } uop_t;

    function automatic uop_t mk_uop(alu_op_t alu, src_t src_a, src_t src_b,
                                    logic neg_a, logic neg_b, logic abs_a,
                                    logic sat, dst_t dst);
        uop_t u;
        u.alu   = alu;
        u.src_a = src_a;
        u.src_b = src_b;
        u.neg_a = neg_a;
        u.neg_b = neg_b;
        u.abs_a = abs_a;
        u.sat   = sat;
        u.dst   = dst;
        return u;
    endfunction

    // Microprogram of one Heun step.
    function automatic uop_t uop_rom(logic [STEP_W-1:0] step);
        uop_t u;
        unique case (step)
            // a0 = accel(x, v)
            5'd0:  u = mk_uop(ALU_ADD,   SRC_VEL,   SRC_ZERO, 1'b0, 1'b0, 1'b1, 1'b0, DST_T1);
            5'd1:  u = mk_uop(ALU_MUL,   SRC_VEL,   SRC_T1,   1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
            5'd2:  u = mk_uop(ALU_RND16, SRC_ZERO,  SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, DST_T1);
            5'd3:  u = mk_uop(ALU_MUL,   SRC_DRAG,  SRC_T1,   1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
            5'd4:  u = mk_uop(ALU_RND16, SRC_ZERO,  SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, DST_T1);
            5'd5:  u = mk_uop(ALU_MUL,   SRC_OMEGA, SRC_POS,  1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
            5'd6:  u = mk_uop(ALU_RND16, SRC_ZERO,  SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, DST_T0);
            5'd7:  u = mk_uop(ALU_ADD,   SRC_T0,    SRC_T1,   1'b1, 1'b1, 1'b0, 1'b1, DST_A0);
            // xp = x + v*dt
            5'd8:  u = mk_uop(ALU_MUL,   SRC_VEL,   SRC_DT,   1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
            5'd9:  u = mk_uop(ALU_RND16, SRC_ZERO,  SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, DST_T0);
            5'd10: u = mk_uop(ALU_ADD,   SRC_POS,   SRC_T0,   1'b0, 1'b0, 1'b0, 1'b1, DST_XP);
            // vp = v + a0*dt
            5'd11: u = mk_uop(ALU_MUL,   SRC_A0,    SRC_DT,   1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
            5'd12: u = mk_uop(ALU_RND16, SRC_ZERO,  SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, DST_T0);
            5'd13: u = mk_uop(ALU_ADD,   SRC_VEL,   SRC_T0,   1'b0, 1'b0, 1'b0, 1'b1, DST_VP);
            // a1 = accel(xp, vp), left in t0
            5'd14: u = mk_uop(ALU_ADD,   SRC_VP,    SRC_ZERO, 1'b0, 1'b0, 1'b1, 1'b0, DST_T1);
            5'd15: u = mk_uop(ALU_MUL,   SRC_VP,    SRC_T1,   1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
            5'd16: u = mk_uop(ALU_RND16, SRC_ZERO,  SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, DST_T1);
            5'd17: u = mk_uop(ALU_MUL,   SRC_DRAG,  SRC_T1,   1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
            5'd18: u = mk_uop(ALU_RND16, SRC_ZERO,  SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, DST_T1);
            5'd19: u = mk_uop(ALU_MUL,   SRC_OMEGA, SRC_XP,   1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
            5'd20: u = mk_uop(ALU_RND16, SRC_ZERO,  SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, DST_T0);
            5'd21: u = mk_uop(ALU_ADD,   SRC_T0,    SRC_T1,   1'b1, 1'b1, 1'b0, 1'b1, DST_T0);
            // x' = x + (v + vp)*dt/2
            5'd22: u = mk_uop(ALU_ADD,   SRC_VEL,   SRC_VP,   1'b0, 1'b0, 1'b0, 1'b0, DST_SUM);
            5'd23: u = mk_uop(ALU_MUL,   SRC_SUM,   SRC_DT,   1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
            5'd24: u = mk_uop(ALU_RND17, SRC_ZERO,  SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, DST_T1);
            5'd25: u = mk_uop(ALU_ADD,   SRC_POS,   SRC_T1,   1'b0, 1'b0, 1'b0, 1'b1, DST_POS);
            // v' = v + (a0 + a1)*dt/2
            5'd26: u = mk_uop(ALU_ADD,   SRC_A0,    SRC_T0,   1'b0, 1'b0, 1'b0, 1'b0, DST_SUM);
            5'd27: u = mk_uop(ALU_MUL,   SRC_SUM,   SRC_DT,   1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
            5'd28: u = mk_uop(ALU_RND17, SRC_ZERO,  SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, DST_T1);
            5'd29: u = mk_uop(ALU_ADD,   SRC_VEL,   SRC_T1,   1'b0, 1'b0, 1'b0, 1'b1, DST_VEL);
            default: u = mk_uop(ALU_ADD, SRC_ZERO,  SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/hdos_alu.sv
module hdos_alu (
    input  logic                                clk,
    input  logic                                en,
    input  hdos_pkg::uop_t                      uop,
    input  logic signed [hdos_pkg::OPND_W-1:0]  opnd_a,
    input  logic signed [hdos_pkg::OPND_W-1:0]  opnd_b,
    output logic signed [hdos_pkg::OPND_W-1:0]  result,
    output logic                                clip
);

    localparam int PW = hdos_pkg::PROD_W;
    localparam int OW = hdos_pkg::OPND_W;
    localparam int SW = hdos_pkg::SUM_W;
    localparam int WW = hdos_pkg::WORD_W;
    localparam int QF = hdos_pkg::Q_FRAC;

    localparam logic signed [PW-1:0] SAT_HI =
        $signed({{(PW-WW+1){1'b0}}, {(WW-1){1'b1}}});
    localparam logic signed [PW-1:0] SAT_LO =
        $signed({{(PW-WW+1){1'b1}}, {(WW-1){1'b0}}});
    localparam logic signed [PW-1:0] BIAS_Q  = $signed(PW'(1) << (QF - 1));
    localparam logic signed [PW-1:0] BIAS_QH = $signed(PW'(1) << QF);

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] rnd_sum;
    logic signed [PW-1:0] rnd_val;
    logic                 na;
    logic                 nb;
    logic [SW-1:0]        ext_a;
    logic [SW-1:0]        ext_b;
    logic [SW-1:0]        add_sum;
    logic signed [PW-1:0] add_val;
    logic [OW:0]          rnd_cl;
    logic [OW:0]          add_cl;

    // {clip, value} of v clamped to the signed word range
    function automatic logic [OW:0] clamp_word(logic signed [PW-1:0] v);
        logic [OW:0] r;
        if (v > SAT_HI)
            r = {1'b1, SAT_HI[OW-1:0]};
        else if (v < SAT_LO)
            r = {1'b1, SAT_LO[OW-1:0]};
        else
            r = {1'b0, v[OW-1:0]};
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en && uop.alu == hdos_pkg::ALU_MUL)
        begin
            prod_reg <= opnd_a * opnd_b;
        end
    end

    // round half up, floor by arithmetic shift
    assign rnd_sum = prod_reg + ((uop.alu == hdos_pkg::ALU_RND17) ? BIAS_QH : BIAS_Q);
    assign rnd_val = (uop.alu == hdos_pkg::ALU_RND17) ? (rnd_sum >>> (QF + 1))
                                                      : (rnd_sum >>> QF);
    assign rnd_cl  = clamp_word(rnd_val);

    assign na      = uop.abs_a ? opnd_a[OW-1] : uop.neg_a;
    assign nb      = uop.neg_b;
    assign ext_a   = {{(SW-OW){opnd_a[OW-1]}}, opnd_a} ^ {SW{na}};
    assign ext_b   = {{(SW-OW){opnd_b[OW-1]}}, opnd_b} ^ {SW{nb}};
    assign add_sum = ext_a + ext_b + SW'(na) + SW'(nb);
    assign add_val = $signed({{(PW-SW){add_sum[SW-1]}}, add_sum});
    assign add_cl  = clamp_word(add_val);

    always_comb
    begin
        result = '0;
        clip   = 1'b0;
        case (uop.alu)
            hdos_pkg::ALU_RND16, hdos_pkg::ALU_RND17:
            begin
                result = $signed(rnd_cl[OW-1:0]);
                clip   = en & rnd_cl[OW];
            end
            hdos_pkg::ALU_ADD:
            begin
                if (uop.sat)
                begin
                    result = $signed(add_cl[OW-1:0]);
                    clip   = en & add_cl[OW];
                end
                else
                begin
                    result = $signed(add_sum[OW-1:0]);
                end
            end
            default:
            begin
                result = '0;
                clip   = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/heun_damped_oscillator_step.sv
// Heun step of an oscillator with quadratic drag, Q16.16 state.
// A step transaction walks the 30 micro-steps in ST_RUN, then waits in ST_HOLD
// until the output register is free; a load goes straight to ST_HOLD.
// A new transaction is taken only in ST_IDLE, once the last result has gone to the
// output register; the shared 33x33 multiplier, its rounder and the adder serve all 30 micro-steps.
// Reset: asynchronous, active low; state clears to zero, registers take defaults.
module heun_damped_oscillator_step (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input transactions
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   op,
    input  logic signed [hdos_pkg::WORD_W-1:0]     load_position,
    input  logic signed [hdos_pkg::WORD_W-1:0]     load_velocity,
    // result transactions
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [hdos_pkg::WORD_W-1:0]     position,
    output logic signed [hdos_pkg::WORD_W-1:0]     velocity,
    output logic                                   saturated,
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [hdos_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hdos_pkg::CFG_W-1:0]             cfg_data
);

    localparam int WW = hdos_pkg::WORD_W;
    localparam int OW = hdos_pkg::OPND_W;
    localparam int CW = hdos_pkg::CFG_W;
    localparam int NW = hdos_pkg::STEP_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,   // take the next input transaction
        ST_RUN  = 3'b010,   // walk the microprogram
        ST_HOLD = 3'b100    // wait for the output register
    } state_t;

    state_t                 state_reg, state_next;
    logic [NW-1:0]          step_reg, step_next;
    logic                   flag_reg, flag_next;
    logic signed [WW-1:0]   pos_reg, pos_next;
    logic signed [WW-1:0]   vel_reg, vel_next;
    logic [CW-1:0]          omega_reg, omega_next;
    logic [CW-1:0]          drag_reg, drag_next;
    logic [CW-1:0]          dt_reg, dt_next;
    logic signed [WW-1:0]   t0_reg, t0_next;
    logic signed [OW-1:0]   t1_reg, t1_next;
    logic signed [WW-1:0]   a0_reg, a0_next;
    logic signed [WW-1:0]   xp_reg, xp_next;
    logic signed [WW-1:0]   vp_reg, vp_next;
    logic signed [OW-1:0]   sum_reg, sum_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [WW-1:0]   out_pos_reg, out_pos_next;
    logic signed [WW-1:0]   out_vel_reg, out_vel_next;
    logic                   out_sat_reg, out_sat_next;

    hdos_pkg::uop_t         uop;
    logic                   alu_en;
    logic signed [OW-1:0]   opnd_a;
    logic signed [OW-1:0]   opnd_b;
    logic signed [OW-1:0]   alu_res;
    logic                   alu_clip;
    logic                   in_fire;
    logic                   out_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign position  = out_pos_reg;
    assign velocity  = out_vel_reg;
    assign saturated = out_sat_reg;

    assign in_fire  = in_valid & in_ready;
    assign out_fire = out_valid_reg & out_ready;

    // Current micro-step and its operands.
    assign uop    = hdos_pkg::uop_rom(step_reg);
    assign alu_en = (state_reg == ST_RUN);

    always_comb
    begin
        case (uop.src_a)
            hdos_pkg::SRC_POS:   opnd_a = {pos_reg[WW-1], pos_reg};
            hdos_pkg::SRC_VEL:   opnd_a = {vel_reg[WW-1], vel_reg};
            hdos_pkg::SRC_OMEGA: opnd_a = $signed({{(OW-CW){1'b0}}, omega_reg});
            hdos_pkg::SRC_DRAG:  opnd_a = $signed({{(OW-CW){1'b0}}, drag_reg});
            hdos_pkg::SRC_DT:    opnd_a = $signed({{(OW-CW){1'b0}}, dt_reg});
            hdos_pkg::SRC_T0:    opnd_a = {t0_reg[WW-1], t0_reg};
            hdos_pkg::SRC_T1:    opnd_a = t1_reg;
            hdos_pkg::SRC_A0:    opnd_a = {a0_reg[WW-1], a0_reg};
            hdos_pkg::SRC_XP:    opnd_a = {xp_reg[WW-1], xp_reg};
            hdos_pkg::SRC_VP:    opnd_a = {vp_reg[WW-1], vp_reg};
            hdos_pkg::SRC_SUM:   opnd_a = sum_reg;
            default:             opnd_a = '0;
        endcase
    end

    always_comb
    begin
        case (uop.src_b)
            hdos_pkg::SRC_POS:   opnd_b = {pos_reg[WW-1], pos_reg};
            hdos_pkg::SRC_VEL:   opnd_b = {vel_reg[WW-1], vel_reg};
            hdos_pkg::SRC_OMEGA: opnd_b = $signed({{(OW-CW){1'b0}}, omega_reg});
            hdos_pkg::SRC_DRAG:  opnd_b = $signed({{(OW-CW){1'b0}}, drag_reg});
            hdos_pkg::SRC_DT:    opnd_b = $signed({{(OW-CW){1'b0}}, dt_reg});
            hdos_pkg::SRC_T0:    opnd_b = {t0_reg[WW-1], t0_reg};
            hdos_pkg::SRC_T1:    opnd_b = t1_reg;
            hdos_pkg::SRC_A0:    opnd_b = {a0_reg[WW-1], a0_reg};
            hdos_pkg::SRC_XP:    opnd_b = {xp_reg[WW-1], xp_reg};
            hdos_pkg::SRC_VP:    opnd_b = {vp_reg[WW-1], vp_reg};
            hdos_pkg::SRC_SUM:   opnd_b = sum_reg;
            default:             opnd_b = '0;
        endcase
    end

    // Shared multiply / round-and-clamp / add unit.
    hdos_alu u_alu (
        .clk    (clk),
        .en     (alu_en),
        .uop    (uop),
        .opnd_a (opnd_a),
        .opnd_b (opnd_b),
        .result (alu_res),
        .clip   (alu_clip)
    );

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        flag_next      = flag_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        omega_next     = omega_reg;
        drag_next      = drag_reg;
        dt_next        = dt_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        a0_next        = a0_reg;
        xp_next        = xp_reg;
        vp_next        = vp_reg;
        sum_next       = sum_reg;
        out_pos_next   = out_pos_reg;
        out_vel_next   = out_vel_reg;
        out_sat_next   = out_sat_reg;
        // drop the result once the consumer takes it
        out_valid_next = out_valid_reg & ~out_fire;

        // Configuration writes; an index past the list is ignored.
        if (cfg_valid)
        begin
            case (hdos_pkg::cfg_reg_t'(cfg_index))
                hdos_pkg::REG_OMEGA_SQ:   omega_next = cfg_data;
                hdos_pkg::REG_DRAG_COEFF: drag_next  = cfg_data;
                hdos_pkg::REG_TIME_STEP:  dt_next    = cfg_data;
                default:                  ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    flag_next = 1'b0;
                    if (op == hdos_pkg::OP_STEP)
                    begin
                        step_next  = '0;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        // load: take the state as given and echo it
                        pos_next   = load_position;
                        vel_next   = load_velocity;
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_RUN:
            begin
                // accumulate any clamp of this transaction
                flag_next = flag_reg | alu_clip;
                case (uop.dst)
                    hdos_pkg::DST_T0:  t0_next  = alu_res[WW-1:0];
                    hdos_pkg::DST_T1:  t1_next  = alu_res;
                    hdos_pkg::DST_A0:  a0_next  = alu_res[WW-1:0];
                    hdos_pkg::DST_XP:  xp_next  = alu_res[WW-1:0];
                    hdos_pkg::DST_VP:  vp_next  = alu_res[WW-1:0];
                    hdos_pkg::DST_SUM: sum_next = alu_res;
                    hdos_pkg::DST_POS: pos_next = alu_res[WW-1:0];
                    hdos_pkg::DST_VEL: vel_next = alu_res[WW-1:0];
                    default:           ;
                endcase
                if (step_reg == hdos_pkg::LAST_STEP)
                    state_next = ST_HOLD;
                else
                    step_next = step_reg + NW'(1);
            end
            ST_HOLD:
            begin
                // hold until the output register is free or being emptied
                if (!out_valid_reg || out_fire)
                begin
                    out_pos_next   = pos_reg;
                    out_vel_next   = vel_reg;
                    out_sat_next   = flag_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control, configuration and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            flag_reg      <= 1'b0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            omega_reg     <= hdos_pkg::OMEGA_SQ_RST;
            drag_reg      <= hdos_pkg::DRAG_COEFF_RST;
            dt_reg        <= hdos_pkg::TIME_STEP_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            flag_reg      <= flag_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            omega_reg     <= omega_next;
            drag_reg      <= drag_next;
            dt_reg        <= dt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Scratch values and the output payload.
    always_ff @(posedge clk)
    begin
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        a0_reg      <= a0_next;
        xp_reg      <= xp_next;
        vp_reg      <= vp_next;
        sum_reg     <= sum_next;
        out_pos_reg <= out_pos_next;
        out_vel_reg <= out_vel_next;
        out_sat_reg <= out_sat_next;
    end

endmodule

FILE: rtl/hdos_chk.sv
`include "heun_damped_oscillator_step_assert.svh"

module hdos_chk (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic                                   op,
    input  logic signed [hdos_pkg::WORD_W-1:0]     load_position,
    input  logic signed [hdos_pkg::WORD_W-1:0]     load_velocity,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic signed [hdos_pkg::WORD_W-1:0]     position,
    input  logic signed [hdos_pkg::WORD_W-1:0]     velocity,
    input  logic                                   saturated,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready
);

    // a step transaction blocks the input side while it runs
    `HDOS_ASSERT_NXT(a_step_busy, in_valid && in_ready && op == hdos_pkg::OP_STEP, !in_ready, "input taken during a step")

    // a load echoes its values, unflagged, through ST_HOLD when the output is free
    `HDOS_ASSERT_NXT(a_load_echo, in_valid && in_ready && op == hdos_pkg::OP_LOAD && (!out_valid || out_ready), ##1 (out_valid && position == $past(load_position, 2) && velocity == $past(load_velocity, 2) && !saturated), "load result wrong or late")

    // configuration writes are never stalled
    `HDOS_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")

    // a stalled result holds
    `HDOS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(position) && $stable(velocity) && $stable(saturated), "stalled result changed")

endmodule

bind heun_damped_oscillator_step hdos_chk u_hdos_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .load_position (load_position),
    .load_velocity (load_velocity),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .position      (position),
    .velocity      (velocity),
    .saturated     (saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);
